// File: sv/snz_pkg.sv
`timescale 1ns / 1ps

package snz_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned HASH_BITS      = 32;
  localparam int unsigned H_BITS         = 31;
  localparam int unsigned NOISE_BITS     = 36;
  localparam int unsigned NUM_LANES      = 9;
  localparam int unsigned NUM_STAGES     = 6;

  localparam logic [HASH_BITS-1:0] Y_MULT     = 32'd57;
  localparam int unsigned          XOR_SHIFT  = 13;
  localparam logic [HASH_BITS-1:0] POLY_MULT  = 32'd15731;
  localparam logic [HASH_BITS-1:0] POLY_ADD   = 32'd789221;
  localparam logic [HASH_BITS-1:0] HASH_ADD   = 32'd1376312589;

  // sixteen unit terms of 2^30 each
  localparam logic [NOISE_BITS-1:0] UNIT_SUM  = 36'h4_0000_0000;

  // lane order: four corners, four sides, centre
  localparam int unsigned LANE_XM_YM = 0;
  localparam int unsigned LANE_XP_YM = 1;
  localparam int unsigned LANE_XM_YP = 2;
  localparam int unsigned LANE_XP_YP = 3;
  localparam int unsigned LANE_XM_Y  = 4;
  localparam int unsigned LANE_XP_Y  = 5;
  localparam int unsigned LANE_X_YM  = 6;
  localparam int unsigned LANE_X_YP  = 7;
  localparam int unsigned LANE_X_Y   = 8;

  typedef struct packed {
    logic load;
    logic square;
    logic poly;
    logic hash;
  } hash_en_t;

  typedef struct packed {
    logic part;
    logic total;
  } sum_en_t;

endpackage

// File: sv/snz_hash_lane.sv
`timescale 1ns / 1ps

module snz_hash_lane
  import snz_pkg::*;
(
  input  logic                 clk_i,
  input  hash_en_t             en_i,
  input  logic [HASH_BITS-1:0] x_i,
  input  logic [HASH_BITS-1:0] y_i,
  output logic [H_BITS-1:0]    h_o
);

  logic [HASH_BITS-1:0] mix_d, mix_q;
  logic [HASH_BITS-1:0] sq_d, sq_q, n2_q;
  logic [HASH_BITS-1:0] poly_d, poly_q, n3_q;
  logic [HASH_BITS-1:0] hash_d;
  logic [H_BITS-1:0]    h_q;

  always_comb begin
    logic [HASH_BITS-1:0] base;
    base   = x_i + y_i * Y_MULT;
    mix_d  = (base << XOR_SHIFT) ^ base;
    sq_d   = mix_q * mix_q;
    poly_d = sq_q * POLY_MULT + POLY_ADD;
    hash_d = n3_q * poly_q + HASH_ADD;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.load) begin
      mix_q <= mix_d;
    end
    if (en_i.square) begin
      sq_q <= sq_d;
      n2_q <= mix_q;
    end
    if (en_i.poly) begin
      poly_q <= poly_d;
      n3_q   <= n2_q;
    end
    if (en_i.hash) begin
      // drop the sign bit
      h_q <= hash_d[H_BITS-1:0];
    end
  end

  assign h_o = h_q;

endmodule

// File: sv/snz_sum.sv
`timescale 1ns / 1ps

module snz_sum
  import snz_pkg::*;
(
  input  logic                  clk_i,
  input  sum_en_t               en_i,
  input  logic [H_BITS-1:0]     h_i [NUM_LANES],
  output logic [NOISE_BITS-1:0] noise_o
);

  localparam int unsigned PART_BITS = H_BITS + 2;

  logic [PART_BITS-1:0]  corner_d, corner_q;
  logic [PART_BITS-1:0]  side_d, side_q;
  logic [H_BITS-1:0]     centre_q;
  logic [NOISE_BITS-1:0] weighted;
  logic [NOISE_BITS-1:0] noise_q;

  always_comb begin
    corner_d = PART_BITS'(h_i[LANE_XM_YM]) + PART_BITS'(h_i[LANE_XP_YM])
             + PART_BITS'(h_i[LANE_XM_YP]) + PART_BITS'(h_i[LANE_XP_YP]);
    side_d   = PART_BITS'(h_i[LANE_XM_Y]) + PART_BITS'(h_i[LANE_XP_Y])
             + PART_BITS'(h_i[LANE_X_YM]) + PART_BITS'(h_i[LANE_X_YP]);
    weighted = NOISE_BITS'(corner_q) + (NOISE_BITS'(side_q) << 1)
             + (NOISE_BITS'(centre_q) << 2);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.part) begin
      corner_q <= corner_d;
      side_q   <= side_d;
      centre_q <= h_i[LANE_X_Y];
    end
    if (en_i.total) begin
      noise_q <= UNIT_SUM - weighted;
    end
  end

  assign noise_o = noise_q;

endmodule

// File: sv/smoothed_integer_noise_2d_unit.sv
`timescale 1ns / 1ps

// Smoothed 2D integer value noise.
// Input channel: in_valid_i / in_ready_o carry one item, a signed lattice
// point (x_coord_i, y_coord_i) of COORD_BITS bits each.
// Output channel: out_valid_o / out_ready_i carry one item per input item,
// noise_value_o, the 3x3 weighted sum of lattice terms scaled by 2^34
// (36-bit two's complement).
// Throughput: one item per cycle while out_ready_i is high. Nine hash lanes work in parallel, each a
// chain of four 32-bit multiplies with one register stage per multiply.
// Pipeline: six register stages (mix, square, polynomial, hash, partial
// sums, final sum); the edge that accepts an item loads the first stage,
// and out_valid_o rises when the item reaches the last stage, which is
// the output register.
// Stalls: each stage advances when it is empty or the stage after it
// advances, so while out_ready_i is low, bubbles still fill and input is
// taken until all six stages hold an item. No item is lost or repeated.
// Reset: clears all stage valid bits; the pipeline comes up empty and
// ready. The data registers are not reset.
module smoothed_integer_noise_2d_unit
  import snz_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] x_coord_i,
  input  logic signed [COORD_BITS-1:0] y_coord_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [NOISE_BITS-1:0] noise_value_o
);

  // Stage valid bits and per-stage advance enables.
  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [NUM_STAGES:0]   stage_en;
  hash_en_t              hash_en;
  sum_en_t               sum_en;

  // Sign-extended point and its neighbors; all wrap at 32 bits.
  logic [HASH_BITS-1:0] x_c, y_c, x_m, x_p, y_m, y_p;
  logic [HASH_BITS-1:0] lane_x [NUM_LANES];
  logic [HASH_BITS-1:0] lane_y [NUM_LANES];
  logic [H_BITS-1:0]    lane_h [NUM_LANES];
  logic [NOISE_BITS-1:0] noise;

  // Advance a stage when it is empty or its successor advances.
  always_comb begin
    stage_en[NUM_STAGES] = out_ready_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (stage_en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (stage_en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign hash_en.load   = stage_en[0];
  assign hash_en.square = stage_en[1];
  assign hash_en.poly   = stage_en[2];
  assign hash_en.hash   = stage_en[3];
  assign sum_en.part    = stage_en[4];
  assign sum_en.total   = stage_en[5];

  assign x_c = HASH_BITS'(x_coord_i);
  assign y_c = HASH_BITS'(y_coord_i);
  assign x_m = x_c - 32'd1;
  assign x_p = x_c + 32'd1;
  assign y_m = y_c - 32'd1;
  assign y_p = y_c + 32'd1;

  always_comb begin
    lane_x[LANE_XM_YM] = x_m;  lane_y[LANE_XM_YM] = y_m;
    lane_x[LANE_XP_YM] = x_p;  lane_y[LANE_XP_YM] = y_m;
    lane_x[LANE_XM_YP] = x_m;  lane_y[LANE_XM_YP] = y_p;
    lane_x[LANE_XP_YP] = x_p;  lane_y[LANE_XP_YP] = y_p;
    lane_x[LANE_XM_Y]  = x_m;  lane_y[LANE_XM_Y]  = y_c;
    lane_x[LANE_XP_Y]  = x_p;  lane_y[LANE_XP_Y]  = y_c;
    lane_x[LANE_X_YM]  = x_c;  lane_y[LANE_X_YM]  = y_m;
    lane_x[LANE_X_YP]  = x_c;  lane_y[LANE_X_YP]  = y_p;
    lane_x[LANE_X_Y]   = x_c;  lane_y[LANE_X_Y]   = y_c;
  end

  // Hash the point and its eight neighbors in parallel.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    snz_hash_lane u_lane (
      .clk_i (clk_i),
      .en_i  (hash_en),
      .x_i   (lane_x[g]),
      .y_i   (lane_y[g]),
      .h_o   (lane_h[g])
    );
  end

  // Weight and combine the nine hashes.
  snz_sum u_sum (
    .clk_i   (clk_i),
    .en_i    (sum_en),
    .h_i     (lane_h),
    .noise_o (noise)
  );

  assign in_ready_o    = stage_en[0];
  assign out_valid_o   = valid_q[NUM_STAGES-1];
  assign noise_value_o = signed'(noise);

`ifndef SYNTHESIS
  // An accepted item occupies the first stage next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted item missing from first stage");

  // Input is refused only when the first stage holds an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> valid_q[0])
    else $error("input refused with empty first stage");

  // A full pipeline with a stalled receiver refuses input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&valid_q) && !out_ready_i |-> !in_ready_o)
    else $error("input taken into a full stalled pipeline");

  // A stage that does not advance keeps its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((valid_q & $past(valid_q & ~stage_en[NUM_STAGES-1:0]))
              == $past(valid_q & ~stage_en[NUM_STAGES-1:0])))
    else $error("stalled stage lost its item");
`endif

endmodule
